/* hdl/ahp_pkg.sv */
// Package for the AC-3 / E-AC-3 sync header parser.
// Holds the field widths, header constants, decode tables and the item types.
// No dependencies.
package ahp_pkg;

   localparam int unsigned HDR_W      = 56;
   localparam int unsigned FBYTES_W   = 13;
   localparam int unsigned SR_W       = 16;
   localparam int unsigned BR_W       = 23;
   localparam int unsigned CH_W       = 3;
   localparam int unsigned DUR_W      = 14;
   localparam int unsigned PROD_W     = FBYTES_W + SR_W;
   localparam int unsigned NUM_W      = 32;

   localparam logic [15:0] SYNC_WORD      = 16'h0B77;
   localparam logic [4:0]  BSID_AC3_MAX   = 5'd10;
   localparam logic [5:0]  FRMSIZECOD_MAX = 6'd37;
   localparam logic [1:0]  CODE_RESERVED  = 2'd3;
   localparam logic [1:0]  FTYPE_RESERVED = 2'd3;
   localparam logic [FBYTES_W-1:0] HDR_BYTES = 13'd7;

   // Index into the block count table {1, 2, 3, 6}.
   localparam logic [1:0] BLK_ONE   = 2'd0;
   localparam logic [1:0] BLK_TWO   = 2'd1;
   localparam logic [1:0] BLK_THREE = 2'd2;
   localparam logic [1:0] BLK_SIX   = 2'd3;

   // 8 bits per byte over blocks of 256 samples: bit rate = product >> 5 / blocks.
   localparam int unsigned BR_SHIFT    = 5;
   // Reciprocal of three, exact for values below 2**25.
   localparam logic [23:0] RECIP3       = 24'hAAAAAB;
   localparam int unsigned RECIP3_SHIFT = 25;
   // 8 bits per byte times 90 kHz.
   localparam logic [NUM_W-1:0] DUR_SCALE = 32'd720000;

   localparam int unsigned DIV_BITS_PER_STEP = 2;
   localparam int unsigned DIV_STEPS = (DUR_W + DIV_BITS_PER_STEP - 1) / DIV_BITS_PER_STEP;

   localparam int unsigned QUEUE_DEPTH = 2;

   typedef struct packed {
      logic                sync_ok;
      logic                enhanced;
      logic [FBYTES_W-1:0] frame_bytes;
      logic                info_ok;
      logic [SR_W-1:0]     sample_rate;
      logic [BR_W-1:0]     bit_rate;
      logic [CH_W-1:0]     channel_count;
      logic [DUR_W-1:0]    duration_ticks;
   } result_type;

   typedef struct packed {
      result_type        res;
      logic [1:0]        blk;
      logic [PROD_W-1:0] prod;
   } entry_type;

   function automatic logic [SR_W-1:0] rate_hz(input logic [1:0] code);
      logic [SR_W-1:0] r;
      case (code)
         2'd0:    r = 16'd48000;
         2'd1:    r = 16'd44100;
         2'd2:    r = 16'd32000;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [CH_W-1:0] chan_of_mode(input logic [2:0] acmod);
      logic [CH_W-1:0] c;
      case (acmod)
         3'd0:    c = 3'd2;
         3'd1:    c = 3'd1;
         3'd2:    c = 3'd2;
         3'd3:    c = 3'd3;
         3'd4:    c = 3'd3;
         3'd5:    c = 3'd4;
         3'd6:    c = 3'd4;
         3'd7:    c = 3'd5;
         default: c = '0;
      endcase
      return c;
   endfunction

   // Nominal AC-3 bit rate in kbit/s, indexed by frmsizecod / 2.
   function automatic logic [9:0] kbps(input logic [4:0] idx);
      logic [9:0] k;
      case (idx)
         5'd0:    k = 10'd32;
         5'd1:    k = 10'd40;
         5'd2:    k = 10'd48;
         5'd3:    k = 10'd56;
         5'd4:    k = 10'd64;
         5'd5:    k = 10'd80;
         5'd6:    k = 10'd96;
         5'd7:    k = 10'd112;
         5'd8:    k = 10'd128;
         5'd9:    k = 10'd160;
         5'd10:   k = 10'd192;
         5'd11:   k = 10'd224;
         5'd12:   k = 10'd256;
         5'd13:   k = 10'd320;
         5'd14:   k = 10'd384;
         5'd15:   k = 10'd448;
         5'd16:   k = 10'd512;
         5'd17:   k = 10'd576;
         5'd18:   k = 10'd640;
         default: k = '0;
      endcase
      return k;
   endfunction

   // Frame size in 16-bit words at 44.1 kHz for the even frmsizecod of each pair.
   function automatic logic [10:0] words_44k(input logic [4:0] idx);
      logic [10:0] w;
      case (idx)
         5'd0:    w = 11'd69;
         5'd1:    w = 11'd87;
         5'd2:    w = 11'd104;
         5'd3:    w = 11'd121;
         5'd4:    w = 11'd139;
         5'd5:    w = 11'd174;
         5'd6:    w = 11'd208;
         5'd7:    w = 11'd243;
         5'd8:    w = 11'd278;
         5'd9:    w = 11'd348;
         5'd10:   w = 11'd417;
         5'd11:   w = 11'd487;
         5'd12:   w = 11'd557;
         5'd13:   w = 11'd696;
         5'd14:   w = 11'd835;
         5'd15:   w = 11'd975;
         5'd16:   w = 11'd1114;
         5'd17:   w = 11'd1253;
         5'd18:   w = 11'd1393;
         default: w = '0;
      endcase
      return w;
   endfunction

   // AC-3 frame size in words for a valid frmsizecod and fscod.
   function automatic logic [10:0] ac3_words(input logic [5:0] fsc, input logic [1:0] fscod);
      logic [10:0] k;
      logic [10:0] w;
      k = {1'b0, kbps(fsc[5:1])};
      case (fscod)
         2'd0:    w = {k[9:0], 1'b0};
         2'd1:    w = words_44k(fsc[5:1]) + {10'd0, fsc[0]};
         2'd2:    w = k * 11'd3;
         default: w = '0;
      endcase
      return w;
   endfunction

endpackage

/* hdl/ahp_req_if.sv */
// Request channel of the header parser: one 7-byte sync header per word.
// Depends on ahp_pkg for the header width.
interface ahp_req_if;
   logic                       valid;
   logic                       ready;
   logic [ahp_pkg::HDR_W-1:0]  header_bits;

   modport source (output valid, output header_bits, input ready);
   modport sink (input valid, input header_bits, output ready);
endinterface

/* hdl/ahp_rsp_if.sv */
// Response channel of the header parser: the decoded fields of one header.
// Depends on ahp_pkg for the field widths.
interface ahp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          sync_ok;
   logic                          enhanced;
   logic [ahp_pkg::FBYTES_W-1:0]  frame_bytes;
   logic                          info_ok;
   logic [ahp_pkg::SR_W-1:0]      sample_rate;
   logic [ahp_pkg::BR_W-1:0]      bit_rate;
   logic [ahp_pkg::CH_W-1:0]      channel_count;
   logic [ahp_pkg::DUR_W-1:0]     duration_ticks;

   modport source (output valid, output sync_ok, output enhanced, output frame_bytes,
                   output info_ok, output sample_rate, output bit_rate,
                   output channel_count, output duration_ticks, input ready);
   modport sink (input valid, input sync_ok, input enhanced, input frame_bytes,
                 input info_ok, input sample_rate, input bit_rate,
                 input channel_count, input duration_ticks, output ready);
endinterface

/* hdl/ahp_front.sv */
// Front end of the header parser: accepts a header word and decodes its fields.
// Depends on ahp_pkg and ahp_req_if; feeds the entry queue.
module ahp_front (
   input  logic                 clock,
   input  logic                 reset,
   ahp_req_if.sink              req_ch,
   output logic                 push_valid,
   input  logic                 push_ready,
   output ahp_pkg::entry_type   push_data
);

   logic                 dec_valid_ff, dec_valid_in;
   ahp_pkg::entry_type   dec_ff, dec_in;
   logic                 accept;

   logic [ahp_pkg::HDR_W-1:0] h;
   logic [ahp_pkg::FBYTES_W-1:0] fs;
   logic [ahp_pkg::SR_W-1:0] sr;
   logic [2:0] acmod;
   logic lfe;
   logic ok;

   assign h = req_ch.header_bits;

   // The A/52 layout puts the LFE flag after optional mix level and surround mode fields.
   always_comb begin
      acmod = h[7:5];
      case (acmod)
         3'd0, 3'd1: lfe = h[4];
         3'd5, 3'd7: lfe = h[0];
         default:    lfe = h[2];
      endcase
   end

   always_comb begin
      dec_in = '0;
      fs     = (({2'b00, h[34:24]}) + 13'd1) << 1;
      sr     = '0;
      ok     = 1'b0;
      if (h[55:40] == ahp_pkg::SYNC_WORD) begin
         if (h[15:11] > ahp_pkg::BSID_AC3_MAX) begin
            dec_in.res.enhanced    = 1'b1;
            dec_in.res.sync_ok     = 1'b1;
            dec_in.res.frame_bytes = fs;
            if (h[23:22] == ahp_pkg::CODE_RESERVED) begin
               sr         = ahp_pkg::rate_hz(h[21:20]) >> 1;
               dec_in.blk = ahp_pkg::BLK_SIX;
            end else begin
               sr         = ahp_pkg::rate_hz(h[23:22]);
               dec_in.blk = h[21:20];
            end
            ok = (h[39:38] != ahp_pkg::FTYPE_RESERVED) && (fs >= ahp_pkg::HDR_BYTES) &&
                 !((h[23:22] == ahp_pkg::CODE_RESERVED) &&
                   (h[21:20] == ahp_pkg::CODE_RESERVED));
            if (ok) begin
               dec_in.res.info_ok       = 1'b1;
               dec_in.res.sample_rate   = sr;
               dec_in.res.channel_count = ahp_pkg::chan_of_mode(h[19:17]) + {2'b00, h[16]};
            end
         end else if ((h[23:22] != ahp_pkg::CODE_RESERVED) &&
                      (h[21:16] <= ahp_pkg::FRMSIZECOD_MAX)) begin
            dec_in.res.sync_ok       = 1'b1;
            dec_in.res.info_ok       = 1'b1;
            dec_in.res.frame_bytes   = {1'b0, ahp_pkg::ac3_words(h[21:16], h[23:22]), 1'b0};
            dec_in.res.sample_rate   = ahp_pkg::rate_hz(h[23:22]);
            dec_in.res.bit_rate      = 23'(ahp_pkg::kbps(h[21:17])) * 23'd1000;
            dec_in.res.channel_count = ahp_pkg::chan_of_mode(acmod) + {2'b00, lfe};
         end
      end
      dec_in.prod = ahp_pkg::PROD_W'(dec_in.res.frame_bytes) *
                    ahp_pkg::PROD_W'(dec_in.res.sample_rate);
   end

   assign req_ch.ready = !dec_valid_ff || push_ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign push_valid   = dec_valid_ff;
   assign push_data    = dec_ff;

   always_comb begin
      if (accept) begin
         dec_valid_in = 1'b1;
      end else if (push_ready) begin
         dec_valid_in = 1'b0;
      end else begin
         dec_valid_in = dec_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_valid_ff <= 1'b0;
      end else begin
         dec_valid_ff <= dec_valid_in;
      end
      if (accept) begin
         dec_ff <= dec_in;
      end
   end

endmodule

/* hdl/ahp_queue.sv */
// Short entry queue between the decode front end and the arithmetic back end.
// Depends on ahp_pkg for the entry type.
module ahp_queue #(
   parameter int unsigned DEPTH = ahp_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  ahp_pkg::entry_type   push_data,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output ahp_pkg::entry_type   pop_data
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   ahp_pkg::entry_type   store_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = store_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hdl/ahp_back.sv */
// Back end of the header parser: E-AC-3 bit rate, then the frame duration
// through a radix-4 restoring divider, then the response register.
// Depends on ahp_pkg and ahp_rsp_if.
module ahp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  ahp_pkg::entry_type   pop_data,
   ahp_rsp_if.source            rsp_ch
);

   localparam int unsigned CNT_W = $clog2(ahp_pkg::DIV_STEPS);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ahp_pkg::DIV_STEPS - 1);
   localparam int unsigned QB = ahp_pkg::DIV_BITS_PER_STEP * ahp_pkg::DIV_STEPS;
   localparam int unsigned BR_W = ahp_pkg::BR_W;

   // Rate stage.
   logic                           s1_valid_ff;
   ahp_pkg::result_type            s1_res_ff, s1_res_in;
   logic [ahp_pkg::NUM_W-1:0]      s1_num_ff, s1_num_in;
   logic [23:0]                    x, x_half, mul_src;
   logic [47:0]                    mul;
   logic [BR_W-1:0]                br_e;

   // Divider.
   logic                           busy_ff;
   logic [CNT_W-1:0]               cnt_ff;
   logic [BR_W-1:0]                rem_ff, rem_in;
   logic [QB-1:0]                  quo_ff, quo_in;
   logic [QB-1:0]                  nsh_ff;
   logic [BR_W-1:0]                dvs_ff;
   ahp_pkg::result_type            dres_ff;

   // Response register.
   logic                           out_valid_ff;
   ahp_pkg::result_type            out_ff, out_in;

   logic out_free, div_done, div_free, div_load, s1_free, step;

   assign out_free  = !out_valid_ff || rsp_ch.ready;
   assign div_done  = busy_ff && (cnt_ff == LAST_STEP);
   assign div_free  = !busy_ff || (div_done && out_free);
   assign div_load  = s1_valid_ff && div_free;
   assign s1_free   = !s1_valid_ff || div_load;
   assign pop_ready = s1_free;
   assign step      = busy_ff && (!div_done || out_free);

   // Divide the scaled product by the block count: halve, and multiply by a
   // reciprocal where a factor of three is involved.
   always_comb begin
      x       = pop_data.prod[ahp_pkg::PROD_W-1:ahp_pkg::BR_SHIFT];
      x_half  = x >> 1;
      mul_src = (pop_data.blk == ahp_pkg::BLK_SIX) ? x_half : x;
      mul     = 48'(mul_src) * 48'(ahp_pkg::RECIP3);
      case (pop_data.blk)
         ahp_pkg::BLK_ONE: br_e = x[BR_W-1:0];
         ahp_pkg::BLK_TWO: br_e = x_half[BR_W-1:0];
         default:          br_e = mul[ahp_pkg::RECIP3_SHIFT +: BR_W];
      endcase
      s1_res_in = pop_data.res;
      if (!pop_data.res.info_ok) begin
         s1_res_in.bit_rate = '0;
      end else if (pop_data.res.enhanced) begin
         s1_res_in.bit_rate = br_e;
      end
      s1_num_in = ahp_pkg::NUM_W'(pop_data.res.frame_bytes) * ahp_pkg::DUR_SCALE;
   end

   // Two restoring division steps per cycle; the last step waits while the response register is full.
   always_comb begin
      logic [BR_W:0] t;
      rem_in = rem_ff;
      quo_in = quo_ff;
      for (int i = 0; i < ahp_pkg::DIV_BITS_PER_STEP; i++) begin
         t = {rem_in, nsh_ff[QB-1-i]};
         if (t >= {1'b0, dvs_ff}) begin
            t      = t - {1'b0, dvs_ff};
            quo_in = {quo_in[QB-2:0], 1'b1};
         end else begin
            quo_in = {quo_in[QB-2:0], 1'b0};
         end
         rem_in = t[BR_W-1:0];
      end
   end

   // The finished word: the carried fields with the duration filled in.
   always_comb begin
      out_in                = dres_ff;
      out_in.duration_ticks = dres_ff.info_ok ? quo_in[ahp_pkg::DUR_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_free) begin
            s1_valid_ff <= pop_valid;
         end
         if (div_load) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (step) begin
            busy_ff <= !div_done;
            cnt_ff  <= cnt_ff + 1'b1;
         end
         if (div_done && out_free) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (pop_valid && s1_free) begin
         s1_res_ff <= s1_res_in;
         s1_num_ff <= s1_num_in;
      end
      if (div_load) begin
         rem_ff  <= BR_W'(s1_num_ff[ahp_pkg::NUM_W-1:QB]);
         nsh_ff  <= s1_num_ff[QB-1:0];
         quo_ff  <= '0;
         dvs_ff  <= s1_res_ff.bit_rate;
         dres_ff <= s1_res_ff;
      end else if (step) begin
         rem_ff <= rem_in;
         nsh_ff <= nsh_ff << ahp_pkg::DIV_BITS_PER_STEP;
         quo_ff <= quo_in;
      end
      if (div_done && out_free) begin
         out_ff <= out_in;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.sync_ok        = out_ff.sync_ok;
   assign rsp_ch.enhanced       = out_ff.enhanced;
   assign rsp_ch.frame_bytes    = out_ff.frame_bytes;
   assign rsp_ch.info_ok        = out_ff.info_ok;
   assign rsp_ch.sample_rate    = out_ff.sample_rate;
   assign rsp_ch.bit_rate       = out_ff.bit_rate;
   assign rsp_ch.channel_count  = out_ff.channel_count;
   assign rsp_ch.duration_ticks = out_ff.duration_ticks;

endmodule

/* hdl/ac3_eac3_header_parser.sv */
// Top level of the AC-3 / E-AC-3 sync header parser.
// Depends on ahp_pkg, ahp_req_if, ahp_rsp_if, ahp_front, ahp_queue and ahp_back.
//
// Each word on the request channel carries one 7-byte sync header, first byte
// in the top eight bits. Each header yields exactly one word on the response
// channel, in order: sync status, the E-AC-3 flag, the frame length in bytes
// and, when the audio fields are valid, sample rate, bit rate, channel count
// and frame duration in 90 kHz ticks. Invalid fields read as zero.
// The front end decodes the header and registers it with the size by rate
// product; a short queue then decouples it from the back end, which derives the
// E-AC-3 bit rate in one registered stage and then divides for the duration.
// The divider resolves two quotient bits per cycle, holding its last step
// while the response register is full, and takes the next header only as it
// finishes the current one, so the divider sets the sustained header rate.
// The response sits in an output register; while the receiver stalls, the
// divider, rate stage, queue and front end keep filling, and the request
// channel only drops ready once all of them are full.
// Synchronous reset empties every stage; no response word is shown afterwards
// until a new header has been accepted.
module ac3_eac3_header_parser #(
   parameter int unsigned QUEUE_DEPTH = ahp_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   ahp_req_if.sink    req_ch,
   ahp_rsp_if.source  rsp_ch
);

   logic                push_valid, push_ready;
   ahp_pkg::entry_type  push_data;
   logic                pop_valid, pop_ready;
   ahp_pkg::entry_type  pop_data;

   ahp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   ahp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   ahp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_ch    (rsp_ch)
   );

endmodule

/* hdl/ahp_checker.sv */
// Port-level checks for the header parser, bound to the top level.
// Depends on ahp_pkg for the field widths.
module ahp_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          sync_ok,
   input logic                          enhanced,
   input logic [ahp_pkg::FBYTES_W-1:0]  frame_bytes,
   input logic                          info_ok,
   input logic [ahp_pkg::SR_W-1:0]      sample_rate,
   input logic [ahp_pkg::BR_W-1:0]      bit_rate,
   input logic [ahp_pkg::CH_W-1:0]      channel_count,
   input logic [ahp_pkg::DUR_W-1:0]     duration_ticks
);

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   a_hold_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(frame_bytes) && $stable(bit_rate) &&
                                  $stable(duration_ticks) && $stable(info_ok))
      else $error("response word changed while stalled");

   a_no_sync: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !sync_ok |-> !enhanced && frame_bytes == '0 && !info_ok)
      else $error("fields set on a header without sync");

   a_no_info: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !info_ok |-> sample_rate == '0 && bit_rate == '0 &&
                                channel_count == '0 && duration_ticks == '0)
      else $error("audio fields set without valid information");

   a_info: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && info_ok |-> sync_ok && bit_rate != '0 && channel_count != '0 &&
                               channel_count <= 3'd6)
      else $error("inconsistent audio information");

endmodule

bind ac3_eac3_header_parser ahp_checker u_ahp_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .sync_ok        (rsp_ch.sync_ok),
   .enhanced       (rsp_ch.enhanced),
   .frame_bytes    (rsp_ch.frame_bytes),
   .info_ok        (rsp_ch.info_ok),
   .sample_rate    (rsp_ch.sample_rate),
   .bit_rate       (rsp_ch.bit_rate),
   .channel_count  (rsp_ch.channel_count),
   .duration_ticks (rsp_ch.duration_ticks)
);
